### rtl/spq_pkg.sv
// Package for the sorted priority queue: operation codes, field widths,
// and the slot and command types shared by the cells and the top level.
// No dependencies.
package spq_pkg;

    localparam int SPQ_DATA_W   = 32;
    localparam int SPQ_COUNT_W  = 5;
    localparam int SPQ_OP_W     = 2;
    localparam int SPQ_CAPACITY = 16;

    localparam logic [SPQ_OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [SPQ_OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [SPQ_OP_W-1:0] OP_CLEAR = 2'd2;

    // One stored entry.
    typedef struct packed {
        logic signed [SPQ_DATA_W-1:0] value;
        logic signed [SPQ_DATA_W-1:0] prio;
    } t_slot;

    // Command broadcast to every cell in the chain.
    typedef struct packed {
        logic  push;
        logic  pop;
        logic  clear;
        t_slot entry;
    } t_cell_cmd;

endpackage

### rtl/spq_if.sv
// Handshake interfaces for the input and result channels of the queue.
// Depends on spq_pkg for the field widths.
interface spq_in_if import spq_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [SPQ_OP_W-1:0]          op;
    logic signed [SPQ_DATA_W-1:0] value;
    logic signed [SPQ_DATA_W-1:0] priority_req;

    modport source (output valid, op, value, priority_req, input ready);
    modport sink   (input valid, op, value, priority_req, output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [SPQ_DATA_W-1:0] head_value;
    logic signed [SPQ_DATA_W-1:0] head_priority;
    logic [SPQ_COUNT_W-1:0]       entry_count;
    logic                         is_empty;
    logic                         is_full;
    logic                         rejected;

    modport source (output valid, head_value, head_priority, entry_count, is_empty,
                    is_full, rejected, input ready);
    modport sink   (input valid, head_value, head_priority, entry_count, is_empty,
                    is_full, rejected, output ready);
endinterface

### rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry and its valid bit, and on a
// push or pop takes the new entry or a neighbor's entry. Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_slot     i_left_slot,
    input  logic      i_left_valid,
    input  logic      i_left_cond,
    input  t_slot     i_right_slot,
    input  logic      i_right_valid,
    output t_slot     o_slot,
    output logic      o_valid,
    output logic      o_cond
);

    t_slot r_slot;
    logic  r_valid;
    logic  w_cond;

    // True from the insertion point onward: the slot is empty or its
    // priority is strictly greater than the pushed one.
    assign w_cond = !r_valid || (r_slot.prio > i_cmd.entry.prio);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.clear) begin
            r_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_valid <= r_valid | i_left_valid;
        end else if (i_cmd.pop) begin
            r_valid <= i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            if (w_cond) begin
                r_slot <= i_left_cond ? i_left_slot : i_cmd.entry;
            end
        end else if (i_cmd.pop) begin
            r_slot <= i_right_slot;
        end
    end

    assign o_slot  = r_slot;
    assign o_valid = r_valid;
    assign o_cond  = w_cond;

endmodule

### rtl/sorted_priority_queue_unit.sv
// Sorted priority queue: a chain of CAPACITY compare-and-shift cells.
// The result of an operation is presented in the cycle after it is accepted.
// Throughput: one operation per cycle while results are taken; every cell compares and shifts in parallel.
// Input is refused only while a result waits unread at the output register.
// Reset (synchronous, active low) empties the queue; entry storage is not cleared.
module sorted_priority_queue_unit import spq_pkg::*; #(
    parameter int CAPACITY = SPQ_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_slot     w_slot  [CAPACITY];
    logic      w_valid [CAPACITY];
    logic      w_cond  [CAPACITY];
    t_cell_cmd w_cmd;

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_out_valid;
    logic                   r_rejected;
    logic                   w_accept;
    logic                   w_full;
    logic                   w_empty;
    logic                   w_reject;
    logic [CNT_W+SPQ_COUNT_W-1:0] w_count_ext;

    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_empty  = (r_count == '0);
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept = i_in.valid && i_in.ready;

    always_comb begin
        w_cmd             = '0;
        w_cmd.entry.value = i_in.value;
        w_cmd.entry.prio  = i_in.priority_req;
        w_reject          = 1'b0;
        n_count           = r_count;
        case (i_in.op)
            OP_PUSH: begin
                w_reject   = w_full;
                w_cmd.push = w_accept && !w_full;
                if (w_cmd.push) begin
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP: begin
                w_reject  = w_empty;
                w_cmd.pop = w_accept && !w_empty;
                if (w_cmd.pop) begin
                    n_count = r_count - 1'b1;
                end
            end
            OP_CLEAR: begin
                w_cmd.clear = w_accept;
                if (w_accept) begin
                    n_count = '0;
                end
            end
            default: begin
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_slot w_lslot;
            logic  w_lvalid;
            logic  w_lcond;
            t_slot w_rslot;
            logic  w_rvalid;

            if (gi == 0) begin : g_head
                assign w_lslot  = w_cmd.entry;
                assign w_lvalid = 1'b1;
                assign w_lcond  = 1'b0;
            end else begin : g_mid_l
                assign w_lslot  = w_slot[gi-1];
                assign w_lvalid = w_valid[gi-1];
                assign w_lcond  = w_cond[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign w_rslot  = '0;
                assign w_rvalid = 1'b0;
            end else begin : g_mid_r
                assign w_rslot  = w_slot[gi+1];
                assign w_rvalid = w_valid[gi+1];
            end

            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_cmd         (w_cmd),
                .i_left_slot   (w_lslot),
                .i_left_valid  (w_lvalid),
                .i_left_cond   (w_lcond),
                .i_right_slot  (w_rslot),
                .i_right_valid (w_rvalid),
                .o_slot        (w_slot[gi]),
                .o_valid       (w_valid[gi]),
                .o_cond        (w_cond[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rejected <= w_reject;
        end
    end

    // The queue state only changes when a new operation is accepted, which
    // happens only once the pending result leaves, so it is read directly.
    assign w_count_ext         = (CNT_W + SPQ_COUNT_W)'(r_count);
    assign o_out.valid         = r_out_valid;
    assign o_out.head_value    = w_valid[0] ? w_slot[0].value : '0;
    assign o_out.head_priority = w_valid[0] ? w_slot[0].prio  : '0;
    assign o_out.entry_count   = w_count_ext[SPQ_COUNT_W-1:0];
    assign o_out.is_empty      = w_empty;
    assign o_out.is_full       = w_full;
    assign o_out.rejected      = r_rejected;

endmodule

### rtl/spq_checker.sv
// Port-level checks for the sorted priority queue, and the bind that
// attaches them to the top level. Depends on spq_pkg.
module spq_checker import spq_pkg::*; (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic signed [SPQ_DATA_W-1:0] i_head_value,
    input logic signed [SPQ_DATA_W-1:0] i_head_priority,
    input logic [SPQ_COUNT_W-1:0]       i_entry_count,
    input logic                         i_is_empty,
    input logic                         i_is_full
);

    // Every accepted transaction produces a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("no result after an accepted transaction");

    // A stalled result keeps its contents.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_head_value)
            && $stable(i_head_priority) && $stable(i_entry_count))
        else $error("result changed while stalled");

    // An empty queue reports a zero head and zero count.
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_empty |-> i_head_value == '0 && i_head_priority == '0
            && i_entry_count == '0 && !i_is_full)
        else $error("empty queue reports a head entry");

    // A nonzero count never reports empty.
    a_count_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_entry_count != '0 |-> !i_is_empty)
        else $error("nonzero count flagged empty");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_head_value    (o_out.head_value),
    .i_head_priority (o_out.head_priority),
    .i_entry_count   (o_out.entry_count),
    .i_is_empty      (o_out.is_empty),
    .i_is_full       (o_out.is_full)
);

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue_unit: a shadow queue predicts the
// head, count and flags after every accepted operation. Depends on spq_pkg and on the
// spq_in_if and spq_out_if interfaces.
module tb;
    import spq_pkg::*;

    localparam logic [SPQ_OP_W-1:0] OP_NONE = 2'd3;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 630;

    typedef struct packed {
        logic signed [SPQ_DATA_W-1:0] head_value;
        logic signed [SPQ_DATA_W-1:0] head_priority;
        logic [SPQ_COUNT_W-1:0]       entry_count;
        logic                         is_empty;
        logic                         is_full;
        logic                         rejected;
    } t_head_report;

    // Mirror of the queue contents plus the reports the block still owes us.
    class queue_mirror;
        t_slot        slots[$];
        t_head_report expected_reports[$];
        int           mismatches;
        int           pushes;
        int           pops;
        int           clears;
        int           rejects;
        int           full_hits;
        int           reports_checked;

        function void apply_op(logic [SPQ_OP_W-1:0] op, logic signed [SPQ_DATA_W-1:0] val,
                               logic signed [SPQ_DATA_W-1:0] pri);
            t_head_report rep;
            t_slot        entry;
            int           pos;
            rep = '0;
            entry.value = val;
            entry.prio = pri;
            pos = 0;
            case (op)
                OP_PUSH: begin
                    pushes++;
                    if (slots.size() >= SPQ_CAPACITY) begin
                        rep.rejected = 1'b1;
                    end else begin
                        // Equal priorities go behind the ones already stored.
                        while (pos < slots.size() && slots[pos].prio <= pri) pos++;
                        slots.insert(pos, entry);
                    end
                end
                OP_POP: begin
                    pops++;
                    if (slots.size() == 0) rep.rejected = 1'b1;
                    else slots.pop_front();
                end
                OP_CLEAR: begin
                    clears++;
                    slots.delete();
                end
                default: ;
            endcase
            if (slots.size() != 0) begin
                rep.head_value = slots[0].value;
                rep.head_priority = slots[0].prio;
            end
            rep.entry_count = SPQ_COUNT_W'(slots.size());
            rep.is_empty = (slots.size() == 0);
            rep.is_full = (slots.size() == SPQ_CAPACITY);
            if (rep.rejected) rejects++;
            if (rep.is_full) full_hits++;
            expected_reports.push_back(rep);
        endfunction

        function void compare_field(string field, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_report(t_head_report got);
            t_head_report want;
            if (expected_reports.size() == 0) begin
                $error("result with no operation outstanding");
                mismatches++;
                return;
            end
            want = expected_reports.pop_front();
            reports_checked++;
            compare_field("head_value", want.head_value, got.head_value);
            compare_field("head_priority", want.head_priority, got.head_priority);
            compare_field("entry_count", want.entry_count, got.entry_count);
            compare_field("is_empty", want.is_empty, got.is_empty);
            compare_field("is_full", want.is_full, got.is_full);
            compare_field("rejected", want.rejected, got.rejected);
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_request;
    int   hold_left;
    int   stall_cycles;
    queue_mirror mirror = new();

    spq_in_if  in_ch ();
    spq_out_if out_ch ();

    sorted_priority_queue_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: checks each transaction and decides ready for the next cycle.
    initial begin
        t_head_report got;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.head_value = out_ch.head_value;
                got.head_priority = out_ch.head_priority;
                got.entry_count = out_ch.entry_count;
                got.is_empty = out_ch.is_empty;
                got.is_full = out_ch.is_full;
                got.rejected = out_ch.rejected;
                mirror.check_report(got);
            end
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[sorted_priority_queue_unit] ERROR");
                $finish;
            end
        end
    end

    task automatic send_item(logic [SPQ_OP_W-1:0] op, logic signed [SPQ_DATA_W-1:0] val,
                             logic signed [SPQ_DATA_W-1:0] pri);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.value <= val;
        in_ch.priority_req <= pri;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        mirror.apply_op(op, val, pri);
    endtask

    task automatic wait_all_results();
        in_ch.valid <= 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [SPQ_DATA_W-1:0] pick_priority();
        int style;
        style = $urandom_range(0, 9);
        if (style < 4) return $urandom_range(0, 6) - 3;   // many ties
        if (style < 8) return $urandom;
        case ($urandom_range(0, 4))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    // Bursts that mostly fill, mostly drain, or mix, so the queue visits every depth.
    task automatic random_traffic(int count);
        int mode;
        int burst;
        int roll;
        logic [SPQ_OP_W-1:0] op;
        mode = 0;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                mode = $urandom_range(0, 2);
                burst = $urandom_range(4, 40);
            end
            burst--;
            roll = $urandom_range(0, 199);
            if (roll < 3) op = OP_CLEAR;
            else if (roll < 6) op = OP_NONE;
            else begin
                case (mode)
                    0: op = (roll < 176) ? OP_PUSH : OP_POP;
                    1: op = (roll < 26) ? OP_PUSH : OP_POP;
                    default: op = (roll < 106) ? OP_PUSH : OP_POP;
                endcase
            end
            send_item(op, $urandom, pick_priority());
        end
    endtask

    initial begin
        hold_request = 0;
        stall_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.op <= OP_PUSH;
        in_ch.value <= '0;
        in_ch.priority_req <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-queue corner cases, extremes, ties, full queue, clear.
        send_item(OP_POP, 32'sd1, 32'sd1);
        send_item(OP_NONE, -32'sd1, -32'sd1);
        send_item(OP_PUSH, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_item(OP_PUSH, 32'sh8000_0000, 32'sh8000_0000);
        send_item(OP_PUSH, 32'sd0, 32'sd0);
        send_item(OP_PUSH, -32'sd1, -32'sd1);
        send_item(OP_PUSH, 32'sd5, 32'sd7);
        send_item(OP_PUSH, 32'sd6, 32'sd7);
        send_item(OP_PUSH, 32'sd7, 32'sd7);
        while (mirror.slots.size() < SPQ_CAPACITY) send_item(OP_PUSH, $urandom, pick_priority());
        send_item(OP_PUSH, 32'sd99, 32'sh8000_0000);
        send_item(OP_NONE, 32'sd0, 32'sd0);
        send_item(OP_POP, 32'sd0, 32'sd0);
        send_item(OP_POP, 32'sd0, 32'sd0);
        send_item(OP_CLEAR, 32'sd0, 32'sd0);
        send_item(OP_POP, 32'sd0, 32'sd0);
        wait_all_results();

        send_idle_pct = 19;
        recv_idle_pct = 70;
        random_traffic(ITEMS_PER_PHASE / 2);
        hold_request = HOLD_OFF_CYCLES;
        random_traffic(ITEMS_PER_PHASE / 2);
        wait_all_results();

        send_idle_pct = 70;
        recv_idle_pct = 19;
        random_traffic(ITEMS_PER_PHASE / 2);
        hold_request = HOLD_OFF_CYCLES;
        random_traffic(ITEMS_PER_PHASE / 2);
        wait_all_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(ITEMS_PER_PHASE);
        wait_all_results();
        repeat (5) @(posedge i_clk);

        $display("Checked %0d results: %0d pushes, %0d pops, %0d clears.",
                 mirror.reports_checked, mirror.pushes, mirror.pops, mirror.clears);
        $display("Saw %0d rejected operations and %0d results with the queue full.",
                 mirror.rejects, mirror.full_hits);
        if (mirror.mismatches == 0 && mirror.pending() == 0) begin
            $display("[sorted_priority_queue_unit] OK");
        end else begin
            $display("[sorted_priority_queue_unit] ERROR");
        end
        $finish;
    end
endmodule
